@@ rtl/sha_pkg.sv @@
// Package for the SHA-256 stream hasher: round constants, initial hash
// values, operation codes, controller state type and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned CountWidth = 61;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] LastBytePos = 6'd63;
  localparam logic [5:0] LenLimitPos = 6'd56;

  localparam logic OpAppend = 1'b0;
  localparam logic OpFinish = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StRound,
    StFold,
    StOut
  } state_e;

  typedef enum logic [1:0] {
    PadFirst,
    PadLength
  } pad_e;

  typedef struct packed {
    logic       put_byte;
    logic       start_pad;
    logic       pad_step;
    logic       load_vars;
    logic       round;
    logic       fold;
    logic       clear_buf;
    logic       write_len;
    logic       restart;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       pad_done;
  } status_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[idx];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h [8];
    h = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    return h[idx];
  endfunction

endpackage

@@ rtl/sha_datapath.sv @@
// Datapath of the SHA-256 hasher: block buffer, message schedule window,
// one-round compression unit, hash words and byte counter. Uses sha_pkg.
`timescale 1ns / 1ps
module sha_datapath import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [5:0]  round_i,
  input  logic [2:0]  out_idx_i,
  output status_t     status_o,
  output logic [31:0] digest_word_o,
  output logic        too_long_o
);

  logic [31:0] buf_q [16];
  logic [31:0] hash_q [8];
  logic [31:0] var_q [8];
  logic [CountWidth-1:0] count_q;
  logic        ovf_q;
  logic [5:0]  pad_pos_q;

  logic [5:0]  pos;
  logic [5:0]  pad_nxt;
  logic [31:0] w0, w1, w9, w14, s0, s1, w_new;
  logic [31:0] big0, big1, ch, maj, t1, t2;
  logic [63:0] bits;

  assign pos = count_q[5:0];
  assign pad_nxt = pad_pos_q + 6'd1;
  assign status_o.pos = pos;
  assign status_o.pad_done = (pad_pos_q == LastBytePos);
  assign bits = {count_q, 3'b000};

  assign w0  = buf_q[0];
  assign w1  = buf_q[1];
  assign w9  = buf_q[9];
  assign w14 = buf_q[14];
  assign s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
  assign s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  assign big1 = {var_q[4][5:0], var_q[4][31:6]} ^ {var_q[4][10:0], var_q[4][31:11]}
              ^ {var_q[4][24:0], var_q[4][31:25]};
  assign ch = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
  assign big0 = {var_q[0][1:0], var_q[0][31:2]} ^ {var_q[0][12:0], var_q[0][31:13]}
              ^ {var_q[0][21:0], var_q[0][31:22]};
  assign maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
  assign t1 = var_q[7] + big1 + ch + round_k(round_i) + w0;
  assign t2 = big0 + maj;

  assign digest_word_o = hash_q[out_idx_i];
  assign too_long_o = ovf_q;

  function automatic logic [31:0] set_byte(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (lane)
      2'd0: r[31:24] = b;
      2'd1: r[23:16] = b;
      2'd2: r[15:8] = b;
      default: r[7:0] = b;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.put_byte) begin
      buf_q[pos[5:2]] <= set_byte(buf_q[pos[5:2]], pos[1:0], data_byte_i);
    end else if (cmd_i.start_pad) begin
      buf_q[pos[5:2]] <= set_byte(buf_q[pos[5:2]], pos[1:0], PadByte);
    end else if (cmd_i.pad_step) begin
      if (!status_o.pad_done) begin
        buf_q[pad_nxt[5:2]] <= set_byte(buf_q[pad_nxt[5:2]], pad_nxt[1:0], 8'h00);
      end
    end else if (cmd_i.clear_buf) begin
      for (int i = 0; i < 16; i++) buf_q[i] <= '0;
    end else if (cmd_i.write_len) begin
      buf_q[14] <= bits[63:32];
      buf_q[15] <= bits[31:0];
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) buf_q[i] <= buf_q[i+1];
      buf_q[15] <= w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_pad) begin
      pad_pos_q <= pos;
    end else if (cmd_i.pad_step && !status_o.pad_done) begin
      pad_pos_q <= pad_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vars) begin
      for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
    end else if (cmd_i.round) begin
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= init_h(3'(i));
      count_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= init_h(3'(i));
        count_q <= '0;
        ovf_q <= 1'b0;
      end else if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
      end
      if (cmd_i.put_byte) begin
        count_q <= count_q + 1'b1;
        if (&count_q) ovf_q <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/sha_ctrl.sv @@
// Controller of the SHA-256 hasher: sequences padding, the 64 rounds,
// hash folding and the digest transactions. Uses sha_pkg.
`timescale 1ns / 1ps
module sha_ctrl import sha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       op_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  status_t    status_i,
  output cmd_t       cmd_o,
  output logic [5:0] round_o,
  output logic [2:0] out_idx_o
);

  state_e state_q, state_d;
  pad_e   phase_q, phase_d;
  logic   fin_q, fin_d;
  logic [5:0] round_q, round_d;
  logic [2:0] idx_q, idx_d;
  logic   in_acc;

  assign round_o = round_q;
  assign out_idx_o = idx_q;
  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign in_acc = in_valid_i && (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= PadFirst;
      fin_q <= 1'b0;
      round_q <= '0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fin_q <= fin_d;
      round_q <= round_d;
      idx_q <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    fin_d = fin_q;
    round_d = round_q;
    idx_d = idx_q;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (in_acc && op_i == OpAppend) begin
          cmd_o.put_byte = 1'b1;
          if (status_i.pos == LastBytePos) begin
            cmd_o.load_vars = 1'b1;
            fin_d = 1'b0;
            round_d = '0;
            state_d = StRound;
          end
        end else if (in_acc) begin
          cmd_o.start_pad = 1'b1;
          fin_d = 1'b1;
          phase_d = (status_i.pos inside {[LenLimitPos:LastBytePos]}) ? PadFirst : PadLength;
          state_d = StPad;
        end
      end
      StPad: begin
        if (status_i.pad_done) begin
          if (phase_q == PadLength) cmd_o.write_len = 1'b1;
          cmd_o.load_vars = 1'b1;
          round_d = '0;
          state_d = StRound;
        end else begin
          cmd_o.pad_step = 1'b1;
        end
      end
      StRound: begin
        cmd_o.round = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == LastRound) state_d = StFold;
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        if (!fin_q) begin
          state_d = StIdle;
        end else if (phase_q == PadFirst) begin
          phase_d = PadLength;
          state_d = StPad;
        end else begin
          idx_d = '0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (&idx_q) begin
            cmd_o.restart = 1'b1;
            fin_d = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StFold && fin_q && phase_q == PadFirst) begin
      cmd_o.clear_buf = 1'b1;
    end
  end

  // A clear pass must land with the pad pointer at its end, so the
  // length write follows on the next cycle through StPad.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |-> !in_acc)
    else $error("Item accepted during compression.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && round_q == LastRound) |=> (state_q == StFold))
    else $error("Compression did not end after the last round.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && &idx_q) |=> (state_q == StIdle))
    else $error("Digest did not end after the last word.");

endmodule

@@ rtl/sha256_stream_hasher_unit.sv @@
// SHA-256 stream hasher, top level. Joins sha_ctrl and sha_datapath.
// An append writes one byte; when it fills a block it also starts a compression
// of 64 rounds on the single round unit, then a fold. A finish pads the
// block, runs one or two compressions, then gives 8 digest transactions.
// Input is stalled while padding, compressing or giving out the digest.
// Reset loads the initial hash values and clears the count and flag.
`timescale 1ns / 1ps
module sha256_stream_hasher_unit import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  output logic        too_long_o
);

  cmd_t       cmd;
  status_t    status;
  logic [5:0] round;
  logic [2:0] idx;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .op_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .status_i(status), .cmd_o(cmd), .round_o(round), .out_idx_o(idx)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .data_byte_i, .round_i(round), .out_idx_i(idx),
    .status_o(status), .digest_word_o, .too_long_o
  );

  assign word_index_o = idx;
  assign last_word_o = &idx;

endmodule
